FILE: rtl/core/vn_pkg.sv
// Package for the value-noise generator: widths, hash constants and the cosine weight table.
package vn_pkg;

    localparam int COORD_W       = 24;
    localparam int OUT_W         = 18;
    localparam int WEIGHT_W      = 17;
    localparam int FRAC_BITS_DEF = 8;
    localparam int INT_BITS_DEF  = 16;
    localparam int TAB_DEPTH     = 256;
    localparam int TAB_IDX_W     = 8;
    localparam int FRAC_MAX_W    = 12;

    localparam logic [31:0] HASH_Y_MUL = 32'd57;
    localparam int          HASH_SHIFT = 13;
    localparam logic [31:0] POLY_A     = 32'd60493;
    localparam logic [31:0] POLY_B     = 32'd19990303;
    localparam logic [31:0] POLY_C     = 32'd1376312589;
    localparam logic [31:0] ONE_Q30    = 32'h4000_0000;

    localparam logic signed [OUT_W-1:0] NOISE_MIN = -18'sd65536;
    localparam logic signed [OUT_W-1:0] NOISE_MAX = 18'sd65536;

    localparam int TQ = 28;
    localparam int WQ = 16;
    localparam logic [63:0] PI_Q = (64'd31415927 << TQ) / 64'd10000000;

    typedef logic [63:0] taylor_div_t [10];
    localparam taylor_div_t TAYLOR_DIV = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420
    };

    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef weight_t weight_tab_t [TAB_DEPTH];

    // stage enables of the corner hash pipe
    typedef struct packed {
        logic xs;
        logic sq;
        logic poly;
        logic fin;
    } hash_en_t;

    // entry i = round(sin^2(pi*i/512) * 2^16), sine by Taylor series in Q.28
    function automatic weight_tab_t build_weights();
        weight_tab_t tab;
        logic [63:0] phi;
        logic [63:0] phi2;
        logic [63:0] term;
        logic [63:0] s;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            phi  = (PI_Q * 64'(i)) / 64'd512;
            phi2 = (phi * phi) >> TQ;
            term = phi;
            s    = phi;
            for (int k = 0; k < 10; k++) begin
                term = ((term * phi2) >> TQ) / TAYLOR_DIV[k];
                if ((k % 2) == 0)
                begin
                    s = s - term;
                end
                else
                begin
                    s = s + term;
                end
            end
            tab[i] = WEIGHT_W'((s * s + (64'd1 << (2*TQ - WQ - 1))) >> (2*TQ - WQ));
        end
        return tab;
    endfunction

    localparam weight_tab_t WEIGHT_TAB = build_weights();

endpackage

FILE: rtl/core/vn_hash.sv
// Four-stage pipelined integer hash of one lattice corner.
module vn_hash
    import vn_pkg::*;
(
    input  logic        clk,
    input  hash_en_t    en,
    input  logic [31:0] n,
    output logic [30:0] nn
);

    logic [30:0] h_reg;
    logic [30:0] h_b_reg;
    logic [30:0] h_c_reg;
    logic [30:0] sq_reg;
    logic [30:0] poly_reg;
    logic [30:0] nn_reg;

    logic [30:0] h_next;
    logic [30:0] sq_next;
    logic [30:0] poly_next;
    logic [30:0] nn_next;

    // only the low 31 bits survive the final mask
    assign h_next    = 31'(n ^ (n << HASH_SHIFT));
    assign sq_next   = 31'(h_reg * h_reg);
    assign poly_next = 31'(sq_reg * 31'(POLY_A) + 31'(POLY_B));
    assign nn_next   = 31'(h_c_reg * poly_reg + 31'(POLY_C));

    always_ff @(posedge clk)
    begin
        if (en.xs)
        begin
            h_reg <= h_next;
        end
        if (en.sq)
        begin
            sq_reg  <= sq_next;
            h_b_reg <= h_reg;
        end
        if (en.poly)
        begin
            poly_reg <= poly_next;
            h_c_reg  <= h_b_reg;
        end
        if (en.fin)
        begin
            nn_reg <= nn_next;
        end
    end

    assign nn = nn_reg;

endmodule

FILE: rtl/core/value_noise_2d.sv
// Top level of the pipelined 2D value-noise generator with cosine blending.
//
// Input channel: x_coord / y_coord, unsigned fixed point (INT_BITS.FRAC_BITS),
// taken on in_valid && in_ready. Output channel: noise_value, signed Q.16 in
// -1..1, delivered on out_valid && out_ready. One result per request, in order.
// Throughput: one request per cycle while out_ready is high; ten register stages, each with a valid bit.
// Stage split: lattice base and weight lookup, xor-shift, square, polynomial,
// final hash multiply, corner differences, two x blends, y difference,
// y blend, rounding into the output register.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up under back-pressure and a request is taken whenever any
// stage has room, even while a finished result waits at the output.
// When out_ready stays low the pipe fills and in_ready drops; nothing is
// lost or repeated.
// Reset clears all valid bits; the pipe is empty and in_ready is high after it.
module value_noise_2d
    import vn_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int INT_BITS  = INT_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [COORD_W-1:0]  x_coord,
    input  logic [COORD_W-1:0]  y_coord,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [OUT_W-1:0]    noise_value
);

    localparam int NSTAGE = 10;
    localparam logic [31:0] IMASK = 32'((64'd1 << INT_BITS) - 64'd1);
    localparam logic [FRAC_MAX_W-1:0] FMASK = FRAC_MAX_W'((64'd1 << FRAC_BITS) - 64'd1);
    localparam int SHR = (FRAC_BITS >= TAB_IDX_W) ? FRAC_BITS - TAB_IDX_W : 0;
    localparam int SHL = (FRAC_BITS <  TAB_IDX_W) ? TAB_IDX_W - FRAC_BITS : 0;
    localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< 45;

    logic [NSTAGE:1] valid_reg;
    logic [NSTAGE:1] valid_next;
    logic [NSTAGE:1] stage_en;

    always_comb
    begin
        stage_en[NSTAGE] = !valid_reg[NSTAGE] || out_ready;
        for (int k = NSTAGE - 1; k >= 1; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign valid_next = {valid_reg[NSTAGE-1:1], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= NSTAGE; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    assign in_ready  = stage_en[1];
    assign out_valid = valid_reg[NSTAGE];

    // stage 1: lattice base index and cosine weights
    logic [31:0] ix;
    logic [31:0] iy;
    logic [31:0] nbase_next;
    logic [FRAC_MAX_W-1:0] frac_x;
    logic [FRAC_MAX_W-1:0] frac_y;
    logic [TAB_IDX_W-1:0]  idx_x;
    logic [TAB_IDX_W-1:0]  idx_y;

    assign ix         = (32'(x_coord) >> FRAC_BITS) & IMASK;
    assign iy         = (32'(y_coord) >> FRAC_BITS) & IMASK;
    assign nbase_next = ix + 32'(iy * HASH_Y_MUL);
    assign frac_x     = FRAC_MAX_W'(x_coord) & FMASK;
    assign frac_y     = FRAC_MAX_W'(y_coord) & FMASK;
    assign idx_x      = TAB_IDX_W'((20'(frac_x) >> SHR) << SHL);
    assign idx_y      = TAB_IDX_W'((20'(frac_y) >> SHR) << SHL);

    logic [31:0] nbase_reg;
    weight_t     fx_reg [1:6];
    weight_t     fy_reg [1:8];

    // stages 2..5: corner hashes
    hash_en_t    hash_en;
    logic [31:0] n_corner  [4];
    logic [30:0] nn_corner [4];

    assign hash_en = '{xs: stage_en[2], sq: stage_en[3], poly: stage_en[4], fin: stage_en[5]};

    assign n_corner[0] = nbase_reg;
    assign n_corner[1] = nbase_reg + 32'd1;
    assign n_corner[2] = nbase_reg + HASH_Y_MUL;
    assign n_corner[3] = nbase_reg + HASH_Y_MUL + 32'd1;

    for (genvar c = 0; c < 4; c++)
    begin : g_corner
        vn_hash u_hash (
            .clk (clk),
            .en  (hash_en),
            .n   (n_corner[c]),
            .nn  (nn_corner[c])
        );
    end

    // stage 6: corner values and x differences
    logic signed [31:0] cs_next;
    logic signed [31:0] cu_next;
    logic signed [31:0] d1_next;
    logic signed [31:0] d2_next;

    assign cs_next = $signed(ONE_Q30 - 32'(nn_corner[0]));
    assign cu_next = $signed(ONE_Q30 - 32'(nn_corner[2]));
    assign d1_next = $signed(32'(nn_corner[0])) - $signed(32'(nn_corner[1]));
    assign d2_next = $signed(32'(nn_corner[2])) - $signed(32'(nn_corner[3]));

    logic signed [31:0] cs_reg;
    logic signed [31:0] cu_reg;
    logic signed [31:0] d1_reg;
    logic signed [31:0] d2_reg;

    // stage 7: blends along x
    logic signed [49:0] prod1;
    logic signed [49:0] prod2;
    logic signed [47:0] b1_next;
    logic signed [47:0] b2_next;

    assign prod1   = d1_reg * $signed({1'b0, fx_reg[6]});
    assign prod2   = d2_reg * $signed({1'b0, fx_reg[6]});
    assign b1_next = 48'(prod1) + (48'(cs_reg) <<< WQ);
    assign b2_next = 48'(prod2) + (48'(cu_reg) <<< WQ);

    logic signed [47:0] b1_reg;
    logic signed [47:0] b2_reg;

    // stage 8: y difference
    logic signed [48:0] db_next;
    logic signed [48:0] db_reg;
    logic signed [47:0] b1d_reg;

    assign db_next = 49'(b2_reg) - 49'(b1_reg);

    // stage 9: blend along y, exact in Q.62
    logic signed [66:0] prod3;
    logic signed [63:0] r_next;
    logic signed [63:0] r_reg;

    assign prod3  = db_reg * $signed({1'b0, fy_reg[8]});
    assign r_next = 64'(prod3) + (64'(b1d_reg) <<< WQ);

    // stage 10: round half up to Q.16
    logic [OUT_W-1:0] noise_next;
    logic [OUT_W-1:0] noise_reg;

    assign noise_next = OUT_W'((r_reg + ROUND_HALF) >>> 46);

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            nbase_reg <= nbase_next;
            fx_reg[1] <= WEIGHT_TAB[idx_x];
            fy_reg[1] <= WEIGHT_TAB[idx_y];
        end
        for (int k = 2; k <= 6; k++)
        begin
            if (stage_en[k])
            begin
                fx_reg[k] <= fx_reg[k-1];
            end
        end
        for (int k = 2; k <= 8; k++)
        begin
            if (stage_en[k])
            begin
                fy_reg[k] <= fy_reg[k-1];
            end
        end
        if (stage_en[6])
        begin
            cs_reg <= cs_next;
            cu_reg <= cu_next;
            d1_reg <= d1_next;
            d2_reg <= d2_next;
        end
        if (stage_en[7])
        begin
            b1_reg <= b1_next;
            b2_reg <= b2_next;
        end
        if (stage_en[8])
        begin
            db_reg  <= db_next;
            b1d_reg <= b1_reg;
        end
        if (stage_en[9])
        begin
            r_reg <= r_next;
        end
        if (stage_en[10])
        begin
            noise_reg <= noise_next;
        end
    end

    assign noise_value = noise_reg;

endmodule

FILE: rtl/core/vn_checker.sv
// Port-level assertions for the value-noise generator, bound to the top level.
module vn_checker
    import vn_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [OUT_W-1:0] noise_value
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(noise_value))
        else $error("stalled result changed or dropped");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(noise_value) >= NOISE_MIN) && ($signed(noise_value) <= NOISE_MAX))
        else $error("noise_value out of range");

    a_backpressure_only: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("request refused without output stall");

endmodule

bind value_noise_2d vn_checker u_vn_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .noise_value (noise_value)
);
